// ===== rtl/core/can_receive_mailbox_table_top_macros.svh =====
`ifndef CAN_RECEIVE_MAILBOX_TABLE_TOP_MACROS_SVH
`define CAN_RECEIVE_MAILBOX_TABLE_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CRMT_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRMT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/can_rmt_pkg.sv =====
package can_rmt_pkg;

    localparam int IDENT_W = 29;
    localparam int HINT_W  = 4;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 2;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    typedef enum logic [2:0] {
        OP_SET_WAIT  = 3'd0,
        OP_ALLOC     = 3'd1,
        OP_RELEASE   = 3'd2,
        OP_STORE     = 3'd3,
        OP_FETCH     = 3'd4,
        OP_FETCH_ANS = 3'd5,
        OP_CHECK     = 3'd6,
        OP_CHECK_ANS = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [IDENT_W-1:0] ident;
        logic               is_extended;
        logic               mark_answer;
        logic [HINT_W-1:0]  slot_hint;
        logic [LEN_W-1:0]   length;
        logic [DATA_W-1:0]  payload;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  out_length;
        logic [DATA_W-1:0] out_payload;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic id_rd;
        logic id_rd_hint;
        logic take_chk;
        logic take_ans;
        logic dat_rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic is_ext;
        logic hint_ok;
        logic scan_hit;
        logic ans_ok;
    } sts_t;

endpackage

// ===== rtl/core/can_rmt_dp.sv =====
module can_rmt_dp import can_rmt_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    localparam int IDX_W = $clog2(SLOT_COUNT)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    input  logic [IDX_W-1:0] scan_addr,
    input  in_item_t         s_item,
    output sts_t             sts,
    output out_item_t        m_item
);

    function automatic logic [DATA_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    in_item_t item_reg;
    op_t      op;

    logic [IDENT_W-1:0] id_mem  [SLOT_COUNT];
    logic [LEN_W-1:0]   len_mem [SLOT_COUNT];
    logic [DATA_W-1:0]  pay_mem [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] id_vld_reg;
    logic [SLOT_COUNT-1:0] pend_reg;

    logic [IDENT_W-1:0] id_rd_reg;
    logic               id_rd_vld_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               found_reg;
    logic               ans_vld_reg;
    logic [IDX_W-1:0]   ans_idx_reg;
    logic [LEN_W-1:0]   dat_len_reg;
    logic [DATA_W-1:0]  dat_pay_reg;
    out_item_t          m_item_reg;
    out_item_t          res;

    logic [IDX_W+3:0]   hint_w;
    logic [IDX_W+3:0]   slot_w;
    logic               hint_ok;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDENT_W-1:0] eff_id;
    logic               id_match;
    logic               id_free;
    logic               chk_pend;
    logic               scan_hit;
    logic [LEN_W-1:0]   store_len;
    logic               id_wr_en;
    logic [IDX_W-1:0]   id_wr_addr;

    assign op       = op_t'(item_reg.mode);
    assign hint_w   = (IDX_W + 4)'(item_reg.slot_hint);
    assign hint_ok  = hint_w < (IDX_W + 4)'(SLOT_COUNT);
    assign rd_addr  = cmd.id_rd_hint ? hint_w[IDX_W-1:0] : scan_addr;
    assign slot_w   = (IDX_W + 4)'(slot_reg);

    // a slot without its valid bit reads as free
    assign eff_id   = id_rd_vld_reg ? id_rd_reg : '0;
    assign id_match = eff_id == item_reg.ident;
    assign id_free  = eff_id == '0;
    assign chk_pend = pend_reg[rd_addr_reg];

    always_comb begin
        case (op) inside
            OP_ALLOC:                      scan_hit = id_free;
            OP_RELEASE, OP_STORE:          scan_hit = id_match;
            OP_FETCH, OP_CHECK:            scan_hit = id_match && chk_pend;
            default:                       scan_hit = 1'b0;
        endcase
    end

    assign sts.op       = op;
    assign sts.is_ext   = item_reg.is_extended;
    assign sts.hint_ok  = hint_ok;
    assign sts.scan_hit = scan_hit;
    assign sts.ans_ok   = ans_vld_reg && pend_reg[ans_idx_reg];

    assign store_len  = (item_reg.length > MAX_LEN) ? MAX_LEN : item_reg.length;
    assign id_wr_en   = cmd.commit &&
                        ((op == OP_SET_WAIT) || ((op == OP_ALLOC) && found_reg));
    assign id_wr_addr = (op == OP_SET_WAIT) ? '0 : slot_reg;

    always_comb begin
        res = '0;
        if (op == OP_SET_WAIT) begin
            res.status = ST_OK;
            res.hit    = 1'b1;
        end else if (found_reg) begin
            res.status = ST_OK;
            res.hit    = 1'b1;
            res.slot   = slot_w[SLOT_W-1:0];
            if ((op == OP_FETCH) || (op == OP_FETCH_ANS)) begin
                res.out_length  = dat_len_reg;
                res.out_payload = dat_pay_reg & len_mask(dat_len_reg);
            end
        end else begin
            res.status = (op == OP_ALLOC) ? ST_FULL : ST_MISS;
        end
    end

    // identifier store
    always_ff @(posedge aclk) begin
        if (id_wr_en) begin
            id_mem[id_wr_addr] <= item_reg.ident;
        end
        if (cmd.id_rd) begin
            id_rd_reg     <= id_mem[rd_addr];
            id_rd_vld_reg <= id_vld_reg[rd_addr];
            rd_addr_reg   <= rd_addr;
        end
    end

    // frame data store
    always_ff @(posedge aclk) begin
        if (cmd.commit && found_reg && (op == OP_STORE)) begin
            len_mem[slot_reg] <= store_len;
            pay_mem[slot_reg] <= item_reg.payload;
        end
        if (cmd.dat_rd) begin
            dat_len_reg <= len_mem[slot_reg];
            dat_pay_reg <= pay_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.commit) begin
            m_item_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_vld_reg  <= '0;
            pend_reg    <= '0;
            ans_vld_reg <= 1'b0;
            ans_idx_reg <= '0;
            found_reg   <= 1'b0;
            slot_reg    <= '0;
        end else begin
            if (cmd.capture) begin
                found_reg <= 1'b0;
                slot_reg  <= '0;
            end else if (cmd.take_chk) begin
                found_reg <= 1'b1;
                slot_reg  <= rd_addr_reg;
            end else if (cmd.take_ans) begin
                found_reg <= 1'b1;
                slot_reg  <= ans_idx_reg;
            end
            if (id_wr_en) begin
                id_vld_reg[id_wr_addr] <= 1'b1;
            end
            if (cmd.commit && found_reg) begin
                case (op) inside
                    OP_RELEASE, OP_FETCH_ANS: begin
                        id_vld_reg[slot_reg] <= 1'b0;
                        pend_reg[slot_reg]   <= 1'b0;
                    end
                    OP_FETCH: pend_reg[slot_reg] <= 1'b0;
                    OP_STORE: pend_reg[slot_reg] <= 1'b1;
                    OP_ALLOC: begin
                        if (item_reg.is_extended) begin
                            ans_vld_reg <= item_reg.mark_answer;
                            if (item_reg.mark_answer) begin
                                ans_idx_reg <= slot_reg;
                            end
                        end else if (item_reg.mark_answer) begin
                            ans_vld_reg <= 1'b1;
                            ans_idx_reg <= slot_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_item = m_item_reg;

endmodule

// ===== rtl/core/can_rmt_ctrl.sv =====
`include "can_receive_mailbox_table_top_macros.svh"

module can_rmt_ctrl import can_rmt_pkg::*; #(
    parameter int SLOT_COUNT     = 16,
    parameter int STANDARD_SLOTS = 8,
    localparam int IDX_W   = $clog2(SLOT_COUNT),
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1),
    localparam int STD_END = (STANDARD_SLOTS < SLOT_COUNT) ? STANDARD_SLOTS : SLOT_COUNT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  sts_t             sts,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] scan_addr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HINT,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic             chk_reg, chk_next;
    logic             out_valid_reg, out_valid_next;
    logic             scan_found;
    logic             scan_more;

    assign scan_found = chk_reg && sts.scan_hit;
    assign scan_more  = addr_reg < hi_reg;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        hi_next    = hi_reg;
        chk_next   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                unique case (sts.op) inside
                    OP_SET_WAIT: state_next = S_FINISH;
                    OP_CHECK_ANS: begin
                        cmd.take_ans = sts.ans_ok;
                        state_next   = S_FINISH;
                    end
                    OP_FETCH_ANS: begin
                        cmd.take_ans = sts.ans_ok;
                        state_next   = sts.ans_ok ? S_READ : S_FINISH;
                    end
                    OP_STORE: begin
                        if (sts.hint_ok) begin
                            cmd.id_rd      = 1'b1;
                            cmd.id_rd_hint = 1'b1;
                            state_next     = S_HINT;
                        end else begin
                            addr_next  = '0;
                            hi_next    = CNT_W'(SLOT_COUNT);
                            state_next = S_SCAN;
                        end
                    end
                    OP_ALLOC, OP_RELEASE: begin
                        // slot 0 is the wait slot
                        addr_next  = sts.is_ext ? CNT_W'(STD_END) : CNT_W'(1);
                        hi_next    = sts.is_ext ? CNT_W'(SLOT_COUNT) : CNT_W'(STD_END);
                        state_next = S_SCAN;
                    end
                    OP_FETCH: begin
                        addr_next  = sts.is_ext ? CNT_W'(STD_END) : '0;
                        hi_next    = sts.is_ext ? CNT_W'(SLOT_COUNT) : CNT_W'(STD_END);
                        state_next = S_SCAN;
                    end
                    OP_CHECK: begin
                        addr_next  = '0;
                        hi_next    = CNT_W'(SLOT_COUNT);
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_HINT: begin
                if (sts.scan_hit) begin
                    cmd.take_chk = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    addr_next  = '0;
                    hi_next    = CNT_W'(SLOT_COUNT);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // reads issue one slot ahead of the compare
                if (scan_found) begin
                    cmd.take_chk = 1'b1;
                    state_next   = (sts.op == OP_FETCH) ? S_READ : S_FINISH;
                end else if (scan_more) begin
                    cmd.id_rd = 1'b1;
                    addr_next = addr_reg + CNT_W'(1);
                    chk_next  = 1'b1;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_READ: begin
                cmd.dat_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            hi_reg        <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            hi_reg        <= hi_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready   = state_reg == S_IDLE;
    assign m_valid   = out_valid_reg;
    assign scan_addr = addr_reg[IDX_W-1:0];

    `CRMT_CHECK(a_scan_bound, state_reg == S_SCAN, (addr_reg <= hi_reg) && (hi_reg <= CNT_W'(SLOT_COUNT)), "scan address out of range")
    `CRMT_CHECK(a_no_overwrite, out_valid_reg && !m_ready, !cmd.commit, "held result overwritten")
    `CRMT_CHECK_NEXT(a_capture_start, cmd.capture, state_reg == S_START, "transfer not started")
    `CRMT_CHECK(a_read_after_find, cmd.dat_rd, ($past(state_reg) == S_SCAN) || ($past(state_reg) == S_START), "data read without a found slot")

endmodule

// ===== rtl/core/can_receive_mailbox_table_top.sv =====
// channel  | ports                      | transfer
// ---------+----------------------------+--------------------------------------
// input    | s_valid, s_ready, s_data   | one operation on the mailbox table
// result   | m_valid, m_ready, m_data   | one result per operation
//
// set wait id and check answer go from start straight to finish, fetch answer reads data between
// a scan reads one slot of its range per cycle until a hit or the end of its range
// a store whose hint misses falls back to a scan, a fetch that hits adds the data read
// the scan rate is set by the one read port of the identifier store
// reset clears every slot through per-slot valid bits, no clearing pass
// a new operation is taken while a result waits; the next result waits in its last cycle
module can_receive_mailbox_table_top import can_rmt_pkg::*; #(
    parameter int SLOT_COUNT     = 16,
    parameter int STANDARD_SLOTS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] scan_addr;

    can_rmt_ctrl #(
        .SLOT_COUNT     (SLOT_COUNT),
        .STANDARD_SLOTS (STANDARD_SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    can_rmt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .s_item    (s_data),
        .sts       (sts),
        .m_item    (m_data)
    );

endmodule
